@@ sv/triangular_window_smoother_macros.svh @@
// Assertion macros for the triangular window smoother.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TRIANGULAR_WINDOW_SMOOTHER_MACROS_SVH
`define TRIANGULAR_WINDOW_SMOOTHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TWS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tws_pkg.sv @@
// Shared constants, register codes and control structs of the smoother.
// No dependencies; the interfaces, the modules and the testbench of the block import it.
package tws_pkg;

	// Field widths fixed by the channel formats
	localparam int IDX_W       = 12;
	localparam int SAMPLE_W    = 32;
	localparam int HALF_CFG_W  = 5;
	localparam int MAX_POINTS  = 4096;

	// Configuration port format
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;

	// Defaults of the top level parameters
	localparam int MAX_HALF_WIDTH_DEF = 16;
	localparam int RING_DEPTH_DEF     = 64;

	// Widest ring address over the supported depth range (up to 256 entries)
	localparam int RING_AW_MAX = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERIES_LAST = 4'd0,
		REG_HALF_WIDTH  = 4'd1
	} cfg_reg_t;

	// Current register contents handed to the sequencer
	typedef struct packed {
		logic [IDX_W-1:0]      last;
		logic [HALF_CFG_W-1:0] half;
	} cfg_t;

	// Ring access command: one write port, one read port
	typedef struct packed {
		logic                   we;
		logic [RING_AW_MAX-1:0] waddr;
		logic                   re;
		logic [RING_AW_MAX-1:0] raddr;
	} ring_cmd_t;

endpackage

@@ sv/tws_in_if.sv @@
// Sample input channel: valid/ready handshake with one complex sample.
// Depends on tws_pkg for the sample width.
interface tws_in_if import tws_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] real_sample;
	logic signed [SAMPLE_W-1:0] imag_sample;

	modport source (output valid, output real_sample, output imag_sample, input ready);
	modport sink (input valid, input real_sample, input imag_sample, output ready);
endinterface

@@ sv/tws_out_if.sv @@
// Result channel: valid/ready handshake with one smoothed sample and its flags.
// Depends on tws_pkg for the index and sample widths.
interface tws_out_if import tws_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [IDX_W-1:0]           sample_index;
	logic signed [SAMPLE_W-1:0] real_smoothed;
	logic signed [SAMPLE_W-1:0] imag_smoothed;
	logic                       run_last;
	logic                       series_end;

	modport source (output valid, output sample_index, output real_smoothed,
		output imag_smoothed, output run_last, output series_end, input ready);
	modport sink (input valid, input sample_index, input real_smoothed,
		input imag_smoothed, input run_last, input series_end, output ready);
endinterface

@@ sv/tws_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on tws_pkg for the index and data widths.
interface tws_cfg_if import tws_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/tws_ring.sv @@
// Sample ring memory: one write port, one read port, registered read data.
// Depends on tws_pkg for the ring command struct.
module tws_ring import tws_pkg::*; #(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int WIDTH = 2 * SAMPLE_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  ring_cmd_t        cmd,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr[AW-1:0]] <= wdata;
		end
	end

	// Read port, registered read data, updated only on a read
	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata <= mem[cmd.raddr[AW-1:0]];
		end
	end

endmodule

@@ sv/tws_div.sv @@
// Signed-by-unsigned long divider, two quotient bits per cycle, truncating toward zero.
// Depends on tws_pkg for default widths.
module tws_div import tws_pkg::*; #(
	parameter int NUM_W = SAMPLE_W + 2 * $clog2(MAX_HALF_WIDTH_DEF + 1) + 1,
	parameter int DEN_W = 2 * $clog2(MAX_HALF_WIDTH_DEF + 1),
	parameter int QUO_W = SAMPLE_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic [QUO_W-1:0]        quo
);

	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int MAG_W = 2 * STEPS;
	localparam int CW    = $clog2(STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic [DEN_W-1:0] den_q;
	logic [MAG_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic [MAG_W-1:0] mag_nx;
	logic [DEN_W:0]   rem_nx;
	logic [NUM_W-1:0] num_mag;

	// Magnitude of the dividend
	assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;

	// Two restoring steps per cycle: shift in a bit, subtract if it fits
	always_comb begin
		rem_nx = rem_q;
		mag_nx = mag_q;
		for (int i = 0; i < 2; i++) begin
			rem_nx = {rem_nx[DEN_W-1:0], mag_nx[MAG_W-1]};
			mag_nx = {mag_nx[MAG_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, den_q}) begin
				rem_nx    = rem_nx - {1'b0, den_q};
				mag_nx[0] = 1'b1;
			end
		end
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Dividend, remainder and operand latches
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= MAG_W'(num_mag);
			rem_q <= '0;
			neg_q <= num[NUM_W-1];
			den_q <= den;
		end else if (busy_q) begin
			mag_q <= mag_nx;
			rem_q <= rem_nx;
		end
	end

	// Restore the sign of the quotient
	assign quo  = neg_q ? QUO_W'(~mag_q + 1'b1) : QUO_W'(mag_q);
	assign done = done_q;

endmodule

@@ sv/tws_seq.sv @@
// Sequencer of the smoother: index counters, window walk over the ring, tap MAC,
// divider hand-off and the output register. Depends on tws_pkg, the sample and result
// channel interfaces and the assertion macro header.
`include "triangular_window_smoother_macros.svh"

module tws_seq import tws_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int LW = $clog2(MAX_HALF_WIDTH + 1),
	localparam int ACC_W = SAMPLE_W + 2 * LW + 1,
	localparam int DIV_W = 2 * LW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg_regs,
	tws_in_if.sink                  samples,
	tws_out_if.source               results,
	output ring_cmd_t               ring_cmd,
	output logic [2*SAMPLE_W-1:0]   ring_wdata,
	input  logic [2*SAMPLE_W-1:0]   ring_rdata,
	output logic                    div_start,
	output logic signed [ACC_W-1:0] div_num_re,
	output logic signed [ACC_W-1:0] div_num_im,
	output logic [DIV_W-1:0]        div_den,
	input  logic                    div_done,
	input  logic [SAMPLE_W-1:0]     quo_re,
	input  logic [SAMPLE_W-1:0]     quo_im
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int TW = LW + 1;
	localparam int NW = $clog2(MAX_HALF_WIDTH + 2);
	localparam logic [AW-1:0] RING_TOP = AW'(RING_DEPTH - 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SCAN   = 8'b0000_0010,
		ST_RD     = 8'b0000_0100,
		ST_TAP    = 8'b0000_1000,
		ST_DRAIN  = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DWAIT  = 8'b0100_0000,
		ST_PUSH   = 8'b1000_0000
	} seq_state_t;

	seq_state_t                 state_q;
	logic [IDX_W-1:0]           icnt_q;
	logic [IDX_W-1:0]           ocnt_q;
	logic [AW-1:0]              wptr_q;
	logic [AW-1:0]              optr_q;
	logic [AW-1:0]              taddr_q;
	logic [IDX_W-1:0]           last_q;
	logic                       end_q;
	logic [NW-1:0]              n_q;
	logic [LW-1:0]              l_q;
	logic                       rl_q;
	logic [TW-1:0]              tap_q;
	logic [DIV_W-1:0]           d_q;
	logic signed [ACC_W-1:0]    acc_re_q;
	logic signed [ACC_W-1:0]    acc_im_q;
	logic [LW-1:0]              w_s1;
	logic                       mac_v_s1;
	logic [SAMPLE_W-1:0]        res_re_q;
	logic [SAMPLE_W-1:0]        res_im_q;
	logic                       out_valid_q;
	logic [IDX_W-1:0]           out_idx_q;
	logic [SAMPLE_W-1:0]        out_re_q;
	logic [SAMPLE_W-1:0]        out_im_q;
	logic                       out_rl_q;
	logic                       out_se_q;

	logic [LW-1:0]              h_sat;
	logic [IDX_W-1:0]           last_eff;
	logic [LW-1:0]              l_cur;
	logic [LW-1:0]              l_nxt;
	logic [LW-1:0]              l_m1;
	logic [IDX_W-1:0]           m_nxt;
	logic [IDX_W:0]             reach_cur;
	logic [IDX_W:0]             reach_nxt;
	logic                       ok_cur;
	logic                       ok_nxt;
	logic [AW-1:0]              start_addr;
	logic [TW-1:0]              tap_end;
	logic [LW-1:0]              w_nx;
	logic                       in_xfer;
	logic                       out_load;
	logic signed [SAMPLE_W-1:0] rd_re;
	logic signed [SAMPLE_W-1:0] rd_im;
	logic signed [SAMPLE_W+TW:0] prod_re;
	logic signed [SAMPLE_W+TW:0] prod_im;

	// Half width at index m of a series ending at lst; zero means pass through
	function automatic logic [LW-1:0] win_half(input logic [IDX_W-1:0] m,
		input logic [IDX_W-1:0] lst, input logic [LW-1:0] h);
		logic [LW-1:0] r;
		r = h;
		if (m == '0) begin
			r = '0;
		end else begin
			if ((m - 1'b1) < IDX_W'(r)) begin
				r = LW'(m - 1'b1);
			end
			if (m > lst) begin
				r = '0;
			end else if ((lst - m) < IDX_W'(r)) begin
				r = LW'(lst - m);
			end
		end
		return r;
	endfunction

	// Advance a ring pointer with wrap
	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == RING_TOP) ? '0 : p + 1'b1;
	endfunction

	// Saturate the register fields
	always_comb begin
		if (int'(cfg_regs.half) > MAX_HALF_WIDTH) begin
			h_sat = LW'(MAX_HALF_WIDTH);
		end else begin
			h_sat = LW'(cfg_regs.half);
		end
		if (int'(cfg_regs.last) > MAX_POINTS - 1) begin
			last_eff = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_eff = cfg_regs.last;
		end
	end

	// Decide whether the next pending output and the one after it are complete
	always_comb begin
		l_cur     = win_half(ocnt_q, last_q, h_sat);
		m_nxt     = ocnt_q + 1'b1;
		l_nxt     = win_half(m_nxt, last_q, h_sat);
		reach_cur = {1'b0, ocnt_q} + (IDX_W+1)'(l_cur);
		reach_nxt = {1'b0, m_nxt} + (IDX_W+1)'(l_nxt);
		ok_cur    = (ocnt_q <= icnt_q) && (int'(n_q) < MAX_HALF_WIDTH + 1)
			&& (reach_cur <= {1'b0, icnt_q});
		ok_nxt    = (ocnt_q < icnt_q) && (int'(n_q) + 1 < MAX_HALF_WIDTH + 1)
			&& (reach_nxt <= {1'b0, icnt_q});
	end

	// First ring address of the window, l-1 entries back from the center
	always_comb begin
		l_m1 = l_cur - 1'b1;
		if (int'(optr_q) >= int'(l_m1)) begin
			start_addr = AW'(int'(optr_q) - int'(l_m1));
		end else begin
			start_addr = AW'(int'(optr_q) + RING_DEPTH - int'(l_m1));
		end
	end

	// Tap weight rises 1..l then falls back to 1
	always_comb begin
		tap_end = {l_q, 1'b0} - TW'(2);
		if (tap_q < TW'(l_q) - TW'(1)) begin
			w_nx = LW'(tap_q + TW'(1));
		end else begin
			w_nx = LW'({l_q, 1'b0} - TW'(1) - tap_q);
		end
	end

	// Handshakes
	assign in_xfer        = samples.valid && samples.ready;
	assign samples.ready  = (state_q == ST_IDLE);
	assign out_load       = (state_q == ST_PUSH) && (!out_valid_q || results.ready);

	// Ring access: the write lands in the accept cycle, reads only in later states
	assign ring_cmd.we    = in_xfer;
	assign ring_cmd.waddr = RING_AW_MAX'(wptr_q);
	assign ring_cmd.re    = ((state_q == ST_SCAN) && ok_cur && (l_cur == '0))
		|| (state_q == ST_TAP);
	assign ring_cmd.raddr = (state_q == ST_TAP) ? RING_AW_MAX'(taddr_q) : RING_AW_MAX'(optr_q);
	assign ring_wdata     = {samples.imag_sample, samples.real_sample};
	assign rd_re          = ring_rdata[SAMPLE_W-1:0];
	assign rd_im          = ring_rdata[2*SAMPLE_W-1:SAMPLE_W];

	// Divider hand-off
	assign div_start  = (state_q == ST_DSTART);
	assign div_num_re = acc_re_q;
	assign div_num_im = acc_im_q;
	assign div_den    = d_q;

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			icnt_q   <= '0;
			ocnt_q   <= '0;
			wptr_q   <= '0;
			optr_q   <= '0;
			taddr_q  <= '0;
			last_q   <= '0;
			end_q    <= 1'b0;
			n_q      <= '0;
			l_q      <= '0;
			rl_q     <= 1'b0;
			tap_q    <= '0;
			mac_v_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= (state_q == ST_TAP);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// An input at or past the last index closes the series
						if (icnt_q >= last_eff) begin
							last_q <= icnt_q;
							end_q  <= 1'b1;
						end else begin
							last_q <= last_eff;
							end_q  <= 1'b0;
						end
						n_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!ok_cur) begin
						// Nothing more to emit for this input: close the step
						if (end_q) begin
							icnt_q <= '0;
							ocnt_q <= '0;
							wptr_q <= '0;
							optr_q <= '0;
						end else begin
							icnt_q <= icnt_q + 1'b1;
							wptr_q <= ring_inc(wptr_q);
						end
						state_q <= ST_IDLE;
					end else begin
						l_q  <= l_cur;
						rl_q <= !ok_nxt;
						if (l_cur == '0) begin
							state_q <= ST_RD;
						end else begin
							taddr_q <= start_addr;
							tap_q   <= '0;
							state_q <= ST_TAP;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PUSH;
				end
				ST_TAP: begin
					taddr_q <= ring_inc(taddr_q);
					tap_q   <= tap_q + 1'b1;
					if (tap_q == tap_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						n_q    <= n_q + 1'b1;
						ocnt_q <= ocnt_q + 1'b1;
						optr_q <= ring_inc(optr_q);
						if (rl_q) begin
							// Last result of this input: close the step
							if (end_q) begin
								icnt_q <= '0;
								ocnt_q <= '0;
								wptr_q <= '0;
								optr_q <= '0;
							end else begin
								icnt_q <= icnt_q + 1'b1;
								wptr_q <= ring_inc(wptr_q);
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tap products, one per cycle behind the ring read
	assign prod_re = rd_re * $signed({1'b0, w_s1});
	assign prod_im = rd_im * $signed({1'b0, w_s1});

	// Accumulate taps, latch the divisor and the result
	always_ff @(posedge clk) begin
		w_s1 <= w_nx;
		if (state_q == ST_SCAN) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (mac_v_s1) begin
			acc_re_q <= acc_re_q + ACC_W'(prod_re);
			acc_im_q <= acc_im_q + ACC_W'(prod_im);
		end
		if (state_q == ST_DRAIN) begin
			d_q <= DIV_W'(l_q) * DIV_W'(l_q);
		end
		if (state_q == ST_RD) begin
			res_re_q <= rd_re;
			res_im_q <= rd_im;
		end else if ((state_q == ST_DWAIT) && div_done) begin
			res_re_q <= quo_re;
			res_im_q <= quo_im;
		end
	end

	// Output register: hold a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= ocnt_q;
			out_re_q  <= res_re_q;
			out_im_q  <= res_im_q;
			out_rl_q  <= rl_q;
			out_se_q  <= (ocnt_q == last_q);
		end
	end

	assign results.valid         = out_valid_q;
	assign results.sample_index  = out_idx_q;
	assign results.real_smoothed = out_re_q;
	assign results.imag_smoothed = out_im_q;
	assign results.run_last      = out_rl_q;
	assign results.series_end    = out_se_q;

	// Between inputs the output index trails the input index by at most the maximum half width
	`TWS_ASSERT_SAME(a_lag_bound, state_q == ST_IDLE, (ocnt_q <= icnt_q) && (int'(icnt_q - ocnt_q) <= MAX_HALF_WIDTH), "output index trails input index too far")
	// The divider only finishes while the sequencer waits for it
	`TWS_ASSERT_SAME(a_div_done_wait, div_done, state_q == ST_DWAIT, "divider finished outside the wait state")
	// A full output register blocks the push
	`TWS_ASSERT_NEXT(a_push_held, (state_q == ST_PUSH) && out_valid_q && !results.ready, state_q == ST_PUSH, "result pushed over a waiting one")

endmodule

@@ sv/triangular_window_smoother.sv @@
// Triangular window smoother of complex samples: configuration registers, ring, divider pair.
// Per input: the sample is accepted and written to the ring, then each result it releases is
// passed through by one ring read, or smoothed by 2*l-1 ring reads for the tap MAC and a
// division by l*l in both dividers; up to MAX_HALF_WIDTH + 1 results per input, 17 by default.
// Reset clears the counters and config registers; ring contents stay undefined, no clear pass.
module triangular_window_smoother import tws_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tws_cfg_if.sink   cfg,
	tws_in_if.sink    samples,
	tws_out_if.source results
);

	localparam int LW    = $clog2(MAX_HALF_WIDTH + 1);
	localparam int ACC_W = SAMPLE_W + 2 * LW + 1;
	localparam int DIV_W = 2 * LW;

	cfg_t                    cfg_q;
	ring_cmd_t               ring_cmd;
	logic [2*SAMPLE_W-1:0]   ring_wdata;
	logic [2*SAMPLE_W-1:0]   ring_rdata;
	logic                    div_start;
	logic signed [ACC_W-1:0] div_num_re;
	logic signed [ACC_W-1:0] div_num_im;
	logic [DIV_W-1:0]        div_den;
	logic                    done_re;
	logic                    done_im;
	logic [SAMPLE_W-1:0]     quo_re;
	logic [SAMPLE_W-1:0]     quo_im;

	// Register writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SERIES_LAST: cfg_q.last <= cfg.data[IDX_W-1:0];
				REG_HALF_WIDTH:  cfg_q.half <= cfg.data[HALF_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tws_seq #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH),
		.RING_DEPTH(RING_DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_q),
		.samples(samples),
		.results(results),
		.ring_cmd(ring_cmd),
		.ring_wdata(ring_wdata),
		.ring_rdata(ring_rdata),
		.div_start(div_start),
		.div_num_re(div_num_re),
		.div_num_im(div_num_im),
		.div_den(div_den),
		.div_done(done_re && done_im),
		.quo_re(quo_re),
		.quo_im(quo_im)
	);

	tws_ring #(
		.DEPTH(RING_DEPTH),
		.WIDTH(2 * SAMPLE_W)
	) u_ring (
		.clk(clk),
		.cmd(ring_cmd),
		.wdata(ring_wdata),
		.rdata(ring_rdata)
	);

	tws_div #(
		.NUM_W(ACC_W),
		.DEN_W(DIV_W),
		.QUO_W(SAMPLE_W)
	) u_div_re (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num_re),
		.den(div_den),
		.done(done_re),
		.quo(quo_re)
	);

	tws_div #(
		.NUM_W(ACC_W),
		.DEN_W(DIV_W),
		.QUO_W(SAMPLE_W)
	) u_div_im (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num_im),
		.den(div_den),
		.done(done_im),
		.quo(quo_im)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of triangular_window_smoother: directed and random complex series,
// predicted in step with every accepted sample. Depends on tws_pkg, the three channel interfaces
// (tws_cfg_if, tws_in_if, tws_out_if) and the smoother RTL.
module tb_top;
	import tws_pkg::*;

	localparam int HALF_CAP       = MAX_HALF_WIDTH_DEF;
	localparam int RING_N         = RING_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 24;
	localparam int END_CYCLES     = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_SAMPLES = 150;
	// Index with no register behind it; writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

	typedef struct packed {
		logic [IDX_W-1:0]           idx;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       run_last;
		logic                       series_end;
	} smooth_res_t;

	logic clk = 1'b0;
	logic arst_n;

	tws_cfg_if cfg_ch();
	tws_in_if  in_ch();
	tws_out_if out_ch();

	triangular_window_smoother dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (in_ch),
		.results (out_ch)
	);

	// Predictor state: raw sample ring, counters and register copies
	logic signed [SAMPLE_W-1:0] ring_re [RING_N];
	logic signed [SAMPLE_W-1:0] ring_im [RING_N];
	int unsigned                series_pos;
	int unsigned                emit_pos;
	logic [IDX_W-1:0]           last_reg;
	logic [HALF_CFG_W-1:0]      half_reg;
	smooth_res_t                pending_smooth [$];

	int mismatches   = 0;
	int idle_cycles  = 0;
	int hold_request = 0;
	int samples_sent = 0;
	bit quiet_send   = 1'b0;
	bit quiet_recv   = 1'b0;
	bit sample_offered = 1'b0;
	bit cfg_offered    = 1'b0;
	bit ready_high     = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Half width of the window at index m in a series ending at last
	function automatic int unsigned taper_half(int unsigned m, int unsigned last);
		int unsigned h;
		h = (half_reg > HALF_CAP) ? HALF_CAP : half_reg;
		if (m == 0)
			return 0;
		if (m - 1 < h)
			h = m - 1;
		if (m > last)
			return 0;
		if (last - m < h)
			h = last - m;
		return h;
	endfunction

	// Weighted window sum over raw samples, divided by l*l toward zero
	function automatic logic signed [SAMPLE_W-1:0] taper_sum(bit imag_part, int unsigned m,
		int unsigned l);
		longint acc;
		int     pos;
		int     w;
		if (l == 0)
			return imag_part ? ring_im[m % RING_N] : ring_re[m % RING_N];
		acc = 0;
		for (int k = -int'(l); k <= int'(l); k++) begin
			pos = int'(m) - k;
			w = int'(l) - ((k < 0) ? -k : k);
			acc += longint'(w) * (imag_part ? longint'(ring_im[pos % RING_N])
				: longint'(ring_re[pos % RING_N]));
		end
		acc = acc / (longint'(l) * longint'(l));
		return acc[SAMPLE_W-1:0];
	endfunction

	// Store one accepted sample and queue every result it releases
	function automatic void advance_series(logic signed [SAMPLE_W-1:0] re,
		logic signed [SAMPLE_W-1:0] im);
		int unsigned j;
		int unsigned last;
		int unsigned m;
		int unsigned l;
		bit          ending;
		smooth_res_t r;
		smooth_res_t batch [$];
		j = series_pos;
		last = last_reg;
		ending = (j >= last);
		if (ending)
			last = j;
		ring_re[j % RING_N] = re;
		ring_im[j % RING_N] = im;
		while (emit_pos <= j && batch.size() < HALF_CAP + 1) begin
			m = emit_pos;
			l = taper_half(m, last);
			if (m + l > j)
				break;
			r.idx = IDX_W'(m);
			r.re = taper_sum(1'b0, m, l);
			r.im = taper_sum(1'b1, m, l);
			r.run_last = 1'b0;
			r.series_end = (m == last);
			batch.push_back(r);
			emit_pos = m + 1;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i])
			pending_smooth.push_back(batch[i]);
		if (ending) begin
			series_pos = 0;
			emit_pos = 0;
		end else begin
			series_pos = (j + 1) & (MAX_POINTS - 1);
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_SERIES_LAST)
			last_reg = data[IDX_W-1:0];
		else if (idx == REG_HALF_WIDTH)
			half_reg = data[HALF_CFG_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic void check_field(string name, logic [SAMPLE_W-1:0] want,
		logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic release_samples();
		if (sample_offered) begin
			in_ch.valid <= 1'b0;
			sample_offered = 1'b0;
		end
	endtask

	task automatic release_cfg();
		if (cfg_offered) begin
			cfg_ch.valid <= 1'b0;
			cfg_offered = 1'b0;
		end
	endtask

	// Offer one sample after a random gap and hold it until the transfer
	task automatic send_sample(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im);
		int gap;
		gap = quiet_send ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			release_samples();
			repeat (gap) @(posedge clk);
		end
		in_ch.real_sample <= re;
		in_ch.imag_sample <= im;
		if (!sample_offered) begin
			in_ch.valid <= 1'b1;
			sample_offered = 1'b1;
		end
		do @(posedge clk); while (!in_ch.ready);
		advance_series(re, im);
		samples_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		if (!cfg_offered) begin
			cfg_ch.valid <= 1'b1;
			cfg_offered = 1'b1;
		end
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, data);
	endtask

	// Stop offering, wait for every expected result, then let the block close its step
	task automatic settle_idle();
		release_samples();
		while (pending_smooth.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Unused upper data bits carry random values
	task automatic configure(int unsigned last, int unsigned half);
		settle_idle();
		write_reg(REG_SERIES_LAST, {4'($urandom), 12'(last)});
		write_reg(REG_HALF_WIDTH, {11'($urandom), 5'(half)});
		release_cfg();
	endtask

	// Registers at reset: every sample is a one point series passed through
	task automatic test_reset_defaults();
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_sample(32'sh0000_0000, -32'sd1);
	endtask

	// Short series with an oversized half width: every window shape up to the far edge
	task automatic test_window_edges();
		logic [SAMPLE_W-1:0] vals [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
		settle_idle();
		write_reg(REG_SPARE, 16'($urandom));
		release_cfg();
		configure(6, 31);
		foreach (vals[i])
			send_sample(vals[i], vals[6 - i]);
	endtask

	task automatic test_pass_through();
		configure(3, 0);
		repeat (4) send_sample(rand_sample(), rand_sample());
	endtask

	// Longest series, then pull the last index below the current one to flush it
	task automatic test_early_end();
		configure(4095, 16);
		repeat (8) send_sample(rand_sample(), rand_sample());
		settle_idle();
		write_reg(REG_SERIES_LAST, {4'($urandom), 12'd2});
		release_cfg();
		send_sample(rand_sample(), rand_sample());
	endtask

	// Receiver holds off while samples keep coming, so the block backs up
	task automatic test_output_hold_off();
		configure(50, 16);
		quiet_send = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (51) send_sample(rand_sample(), rand_sample());
		quiet_send = 1'b0;
	endtask

	// Drain mid-series, then narrow the window for the rest of it
	task automatic test_mid_series_pause();
		configure(30, 5);
		repeat (12) send_sample(rand_sample(), rand_sample());
		settle_idle();
		write_reg(REG_HALF_WIDTH, {11'($urandom), 5'd2});
		release_cfg();
		do send_sample(rand_sample(), rand_sample()); while (series_pos != 0);
	endtask

	// Whole series with random settings, some changed or cut short midway
	task automatic test_random_series();
		int start;
		int last;
		int half;
		int cut;
		start = samples_sent;
		while (samples_sent - start < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 9))
				0: last = 0;
				1: last = $urandom_range(64, 90);
				default: last = $urandom_range(1, 40);
			endcase
			half = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
			quiet_send = ($urandom_range(0, 4) == 0);
			quiet_recv = ($urandom_range(0, 4) == 0);
			configure(last, half);
			cut = ($urandom_range(0, 3) == 0 && last > 2) ? $urandom_range(1, last - 1) : -1;
			do begin
				send_sample(rand_sample(), rand_sample());
				if (int'(series_pos) == cut) begin
					settle_idle();
					if ($urandom_range(0, 1))
						write_reg(REG_HALF_WIDTH, {11'($urandom), 5'($urandom)});
					else
						write_reg(REG_SERIES_LAST, {4'($urandom),
							12'($urandom_range((cut > 8) ? cut - 8 : 0, cut + 20))});
					release_cfg();
				end
			end while (series_pos != 0);
		end
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
	endtask

	// Receiver: random stalls per result, or one long hold-off on request
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = quiet_recv ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				if (ready_high) begin
					out_ch.ready <= 1'b0;
					ready_high = 1'b0;
				end
				repeat (stall) @(posedge clk);
			end
			if (!ready_high) begin
				out_ch.ready <= 1'b1;
				ready_high = 1'b1;
			end
			do @(posedge clk); while (!out_ch.valid && hold_request == 0);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		smooth_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_smooth.size() == 0) begin
				$error("result with nothing expected, sample_index %0d", out_ch.sample_index);
				mismatches++;
			end else begin
				want = pending_smooth.pop_front();
				check_field("sample_index", want.idx, out_ch.sample_index);
				check_field("real_smoothed", want.re, out_ch.real_smoothed);
				check_field("imag_smoothed", want.im, out_ch.imag_smoothed);
				check_field("run_last", want.run_last, out_ch.run_last);
				check_field("series_end", want.series_end, out_ch.series_end);
			end
		end
	end

	// End the run when no channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.real_sample <= '0;
		in_ch.imag_sample <= '0;
		last_reg = '0;
		half_reg = '0;
		series_pos = 0;
		emit_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_window_edges();
		test_pass_through();
		test_early_end();
		test_output_hold_off();
		test_mid_series_pause();
		test_random_series();

		release_samples();
		while (pending_smooth.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
